// ----- rtl/core/mhw_pkg.sv -----
// Package for the multi-arm heartbeat watchdog: field widths, reset values,
// operation and register-index codes, and the structs passed between modules.
// No dependencies.
package mhw_pkg;

   localparam int ARM_COUNT_DEFAULT = 4;
   localparam int ARM_W             = 2;
   localparam int ZONE_W            = 8;
   localparam int TIME_W            = 32;
   localparam int LIMIT_W           = 20;
   localparam int CSR_DATA_W        = 20;
   localparam int CSR_INDEX_W       = 1;

   localparam logic [LIMIT_W-1:0] STALE_LIMIT_RESET = LIMIT_W'(3000);
   localparam logic [ZONE_W-1:0]  FORBIDDEN_RESET   = ZONE_W'(5);

   typedef enum logic [0:0] {
      OP_ARRIVAL = 1'b0,
      OP_CHECK   = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STALE_LIMIT    = 1'b0,
      CSR_FORBIDDEN_ZONE = 1'b1
   } csr_index_type;

   // one heartbeat or check word, as held in the input register
   typedef struct packed {
      op_type              op;
      logic [ARM_W-1:0]    arm;
      logic [ZONE_W-1:0]   zone;
      logic [TIME_W-1:0]   now_time;
   } item_type;

   // what the result stage needs to know about the word being retired
   typedef struct packed {
      logic   load;
      op_type op;
      logic   zone_hit;
      logic   stale;
   } event_type;

endpackage

// ----- rtl/core/multi_arm_heartbeat_watchdog_unit.sv -----
// Top level of the multi-arm heartbeat watchdog: input register, config
// registers, arm table and result stage. Depends on mhw_pkg, mhw_arm_table,
// mhw_result_stage.
//
//   port group  | dir | handshake         | word
//   req_*       | in  | req_valid/ready   | operation, arm, zone, now_time
//   rsp_*       | out | rsp_valid/ready   | healthy, park
//   csr_*       | in  | csr_write_enable  | index (0 stale limit, 1 zone), data
//
// One word per cycle sustained while rsp_ready stays high. A word passes from the
// input register to the result register, where rsp_valid rises with it; all
// arms' ages are compared with the limit in parallel between the two registers.
// Synchronous reset clears last-heard times, park and both valids, and loads the
// stale limit (3000 us) and forbidden zone (5). A stalled result holds the input
// register; req_ready drops only when both registers are full and rsp_ready is low.
module multi_arm_heartbeat_watchdog_unit #(
   parameter int ARM_COUNT = mhw_pkg::ARM_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // heartbeat / check words
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [mhw_pkg::ARM_W-1:0]        req_arm,
   input  logic [mhw_pkg::ZONE_W-1:0]       req_zone,
   input  logic [mhw_pkg::TIME_W-1:0]       req_now_time,
   // result words
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_healthy,
   output logic                             rsp_park,
   // register writes
   input  logic                             csr_write_enable,
   input  logic [mhw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mhw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mhw_pkg::*;

   // configuration
   logic [LIMIT_W-1:0] stale_limit_ff, stale_limit_in;
   logic [ZONE_W-1:0]  forbidden_ff,   forbidden_in;

   // input register
   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff,  in_item_in;

   logic      slot_free;
   logic      advance;
   logic      any_stale;
   event_type evt;

   always_comb begin
      stale_limit_in = stale_limit_ff;
      forbidden_in   = forbidden_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STALE_LIMIT:    stale_limit_in = csr_wdata[LIMIT_W-1:0];
            CSR_FORBIDDEN_ZONE: forbidden_in   = csr_wdata[ZONE_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= STALE_LIMIT_RESET;
         forbidden_ff   <= FORBIDDEN_RESET;
      end else begin
         stale_limit_ff <= stale_limit_in;
         forbidden_ff   <= forbidden_in;
      end
   end

   // the held word moves on whenever the result register can take it
   assign advance   = in_valid_ff && slot_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = '{op:       op_type'(req_operation),
                         arm:      req_arm,
                         zone:     req_zone,
                         now_time: req_now_time};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // last-heard store; written only by an arrival as it retires
   mhw_arm_table #(
      .ARM_COUNT (ARM_COUNT)
   ) u_arm_table (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (advance && (in_item_ff.op == OP_ARRIVAL)),
      .item        (in_item_ff),
      .stale_limit (stale_limit_ff),
      .any_stale   (any_stale)
   );

   assign evt = '{load:     advance,
                  op:       in_item_ff.op,
                  zone_hit: (in_item_ff.zone == forbidden_ff),
                  stale:    any_stale};

   mhw_result_stage u_result_stage (
      .clock       (clock),
      .reset       (reset),
      .evt         (evt),
      .rsp_ready   (rsp_ready),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_healthy (rsp_healthy),
      .rsp_park    (rsp_park)
   );

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held word lost while result stalled");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && in_valid_ff) |-> !req_ready)
      else $error("word accepted with both stages full");

   a_forbidden_parks: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.op == OP_ARRIVAL && in_item_ff.zone == forbidden_ff)
      |=> rsp_park)
      else $error("forbidden zone did not park");

endmodule

// ----- rtl/core/mhw_arm_table.sv -----
// Last-heard time per arm and the parallel age comparators.
// Depends on mhw_pkg.
module mhw_arm_table #(
   parameter int ARM_COUNT = mhw_pkg::ARM_COUNT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  mhw_pkg::item_type            item,
   input  logic [mhw_pkg::LIMIT_W-1:0]  stale_limit,
   output logic                         any_stale
);
   import mhw_pkg::*;

   logic [TIME_W-1:0] last_heard_ff [ARM_COUNT];
   logic [TIME_W-1:0] last_heard_in [ARM_COUNT];
   logic [ARM_COUNT-1:0] stale_vec;

   for (genvar k = 0; k < ARM_COUNT; k++) begin : g_arm
      logic          hit;
      logic [TIME_W-1:0] age;

      // arm field is narrower than the table can be; upper slots never written
      assign hit = wr_en && (k < (1 << ARM_W)) && (32'(item.arm) == k);
      assign last_heard_in[k] = hit ? item.now_time : last_heard_ff[k];

      // modular age, limit zero-extended; equal to limit is still healthy
      assign age          = item.now_time - last_heard_ff[k];
      assign stale_vec[k] = age > TIME_W'(stale_limit);

      always_ff @(posedge clock) begin
         if (reset) begin
            last_heard_ff[k] <= '0;
         end else begin
            last_heard_ff[k] <= last_heard_in[k];
         end
      end
   end

   assign any_stale = |stale_vec;

   // an arrival for arm 0 leaves its time behind
   a_arm0_store: assert property (@(posedge clock) disable iff (reset)
      (wr_en && item.arm == '0) |=> last_heard_ff[0] == $past(item.now_time))
      else $error("arm 0 last-heard time not stored");

endmodule

// ----- rtl/core/mhw_result_stage.sv -----
// Sticky park flag and the output register of the result channel.
// Depends on mhw_pkg.
module mhw_result_stage (
   input  logic               clock,
   input  logic               reset,
   input  mhw_pkg::event_type evt,
   input  logic               rsp_ready,
   output logic               slot_free,
   output logic               rsp_valid,
   output logic               rsp_healthy,
   output logic               rsp_park
);
   import mhw_pkg::*;

   logic park_ff,    park_in;
   logic valid_ff,   valid_in;
   logic healthy_ff, healthy_in;
   logic rpark_ff,   rpark_in;
   logic trip;

   assign trip = (evt.op == OP_ARRIVAL) ? evt.zone_hit : evt.stale;

   always_comb begin
      park_in    = park_ff;
      valid_in   = valid_ff;
      healthy_in = healthy_ff;
      rpark_in   = rpark_ff;
      if (evt.load) begin
         park_in    = park_ff | trip;
         valid_in   = 1'b1;
         healthy_in = !((evt.op == OP_CHECK) && evt.stale);
         rpark_in   = park_ff | trip;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         park_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         park_ff  <= park_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      healthy_ff <= healthy_in;
      rpark_ff   <= rpark_in;
   end

   assign slot_free   = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_healthy = healthy_ff;
   assign rsp_park    = rpark_ff;

   a_park_sticky: assert property (@(posedge clock) disable iff (reset)
      park_ff |=> park_ff)
      else $error("park flag cleared without reset");

   a_unhealthy_parks: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !healthy_ff) |-> rpark_ff)
      else $error("unhealthy word without park");

   a_arrival_healthy: assert property (@(posedge clock) disable iff (reset)
      (evt.load && evt.op == OP_ARRIVAL) |=> (valid_ff && healthy_ff))
      else $error("arrival reported unhealthy");

endmodule

// ----- tb/multi_arm_heartbeat_watchdog_unit_tb.sv -----
// Self-checking bench for multi_arm_heartbeat_watchdog_unit: a directed table,
// then randomised heartbeat/check phases under several limit and zone settings.
// Depends on mhw_pkg and the watchdog RTL only.
module multi_arm_heartbeat_watchdog_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mhw_pkg::*;

   localparam int ARMS        = ARM_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 64;   // long receiver hold-off, fills the pipe
   localparam int DIRECTED_N  = 16;

   // healthy/park pair as returned on the rsp side
   typedef struct packed {
      logic healthy;
      logic park;
   } verdict_type;

   // per-word tag: pinned words carry a hand-written verdict
   typedef struct packed {
      logic        pinned;
      verdict_type verdict;
   } note_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  arm;
      logic [7:0]  zone;
      logic [31:0] stamp;
      note_type    note;
   } probe_type;

   localparam note_type FREE_NOTE = '{1'b0, '{1'b0, 1'b0}};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_operation = 1'b0;
   logic [ARM_W-1:0]        req_arm = '0;
   logic [ZONE_W-1:0]       req_zone = '0;
   logic [TIME_W-1:0]       req_now_time = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_healthy;
   logic                    rsp_park;
   logic                    csr_write_enable = 1'b0;
   csr_index_type           csr_index = CSR_STALE_LIMIT;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   multi_arm_heartbeat_watchdog_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_arm          (req_arm),
      .req_zone         (req_zone),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_healthy      (rsp_healthy),
      .rsp_park         (rsp_park),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Watchdog shadow: last-heard times, sticky park, and the two CSRs.
   // ------------------------------------------------------------------
   logic [31:0]      heard_shadow[ARMS];
   logic             park_shadow;
   logic [19:0]      limit_shadow;
   logic [7:0]       forbidden_shadow;

   verdict_type      owed_verdicts[$];   // results still to come back, oldest first
   note_type         pending_notes[$];   // one tag per word offered, in order

   int unsigned      cycle_count     = 0;
   int unsigned      mismatch_count  = 0;
   int unsigned      words_accepted  = 0;
   int unsigned      arrivals_seen   = 0;
   int unsigned      checks_seen     = 0;
   int unsigned      unhealthy_seen  = 0;
   int unsigned      results_checked = 0;
   int unsigned      input_stalls    = 0;
   int unsigned      settings_run    = 0;
   int unsigned      burst_left      = 0;
   bit               hold_done       = 1'b0;

   // Apply one word to the shadow state and return the verdict it yields.
   // Arrival: stamp the arm, latch park on the forbidden zone.
   // Check: any arm older than the limit (mod 2^32) latches park, unhealthy.
   function automatic verdict_type watchdog_step(input op_type op, input logic [1:0] arm,
                                                 input logic [7:0] zone,
                                                 input logic [31:0] stamp);
      verdict_type v;
      logic [31:0] age;
      v.healthy = 1'b1;
      if (op == OP_ARRIVAL) begin
         if (int'(arm) < ARMS)
            heard_shadow[arm] = stamp;
         if (zone == forbidden_shadow)
            park_shadow = 1'b1;
      end else begin
         for (int k = 0; k < ARMS; k++) begin
            age = stamp - heard_shadow[k];
            if (age > 32'(limit_shadow))
               v.healthy = 1'b0;
         end
         if (!v.healthy)
            park_shadow = 1'b1;
      end
      v.park = park_shadow;
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Monitor. Everything is sampled on the rising edge, before the
   // nonblocking updates of that edge land, so there is no race with
   // either the DUT or the drivers below.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      note_type    note;
      verdict_type v;
      verdict_type owed;
      if (reset) begin
         for (int k = 0; k < ARMS; k++)
            heard_shadow[k] = '0;
         park_shadow      = 1'b0;
         limit_shadow     = STALE_LIMIT_RESET;
         forbidden_shadow = FORBIDDEN_RESET;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STALE_LIMIT:    limit_shadow = csr_wdata[LIMIT_W-1:0];
               CSR_FORBIDDEN_ZONE: forbidden_shadow = csr_wdata[ZONE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_ready)
            input_stalls++;
         // results first: a word accepted now cannot answer on this edge
         if (rsp_valid && rsp_ready) begin
            if (owed_verdicts.size() == 0) begin
               report_mismatch("result with nothing outstanding");
            end else begin
               owed = owed_verdicts.pop_front();
               if (rsp_healthy !== owed.healthy)
                  report_mismatch($sformatf("healthy %b, expected %b",
                                            rsp_healthy, owed.healthy));
               if (rsp_park !== owed.park)
                  report_mismatch($sformatf("park %b, expected %b", rsp_park, owed.park));
            end
            if (rsp_healthy === 1'b0)
               unhealthy_seen++;
            results_checked++;
         end
         if (req_valid && req_ready) begin
            note = pending_notes.pop_front();
            v = watchdog_step(op_type'(req_operation), req_arm, req_zone, req_now_time);
            // table rows with a typed-in verdict override the shadow's answer
            if (note.pinned)
               v = note.verdict;
            owed_verdicts.push_back(v);
            words_accepted++;
            if (op_type'(req_operation) == OP_ARRIVAL)
               arrivals_seen++;
            else
               checks_seen++;
         end
      end
   end

   // watchdog for the bench itself
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding",
                  cycle_count, owed_verdicts.size());
         $display("multi_arm_heartbeat_watchdog_unit_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall pattern, occasional clean stretches, and one
   // long hold-off once traffic is flowing so that both pipeline
   // registers fill and req_ready drops while the sender keeps offering.
   // ------------------------------------------------------------------
   initial begin
      int style;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         style = $urandom_range(0, 9);
         if (!hold_done && results_checked >= 150) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (style <= 5) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else if (style <= 8) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (40) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called at a rising edge; returns at the edge the word is
   // taken. Valid stays up across a burst, so back-to-back words only
   // ever see one assignment to req_valid per edge.
   // ------------------------------------------------------------------
   task automatic send_word(input op_type op, input logic [1:0] arm,
                            input logic [7:0] zone, input logic [31:0] stamp,
                            input note_type note);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pending_notes.push_back(note);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_arm       <= arm;
      req_zone      <= zone;
      req_now_time  <= stamp;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid and wait for every owed result. Each word answers exactly
   // once, so an empty store means the block is idle.
   task automatic drain;
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (owed_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // Both registers, limit written twice so the second write must win.
   // Zone data carries junk above bit 7, which the block must drop.
   task automatic set_config(input logic [19:0] lim, input logic [7:0] zone_code);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_STALE_LIMIT;
      csr_wdata        <= 20'($urandom);
      @(posedge clock);
      csr_wdata        <= lim;
      @(posedge clock);
      csr_index        <= CSR_FORBIDDEN_ZONE;
      csr_wdata        <= {12'($urandom), zone_code};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_run++;
   endtask

   // mostly random zones, one in eight the forbidden code
   function automatic logic [7:0] pick_zone(input logic [7:0] zone_code);
      return ($urandom_range(0, 7) == 0) ? zone_code : 8'($urandom);
   endfunction

   // One randomised phase. Arms heartbeat mostly round-robin on an advancing
   // clock with random steps; checks land on the current time or right on
   // an arm's age limit (limit-1, limit, limit+1); a tenth is raw noise.
   task automatic run_phase(input logic [19:0] lim, input logic [7:0] zone_code,
                            input int words);
      logic [31:0] t_us;
      logic [31:0] step_us;
      logic [31:0] heard_at[ARMS];
      logic [31:0] stamp;
      logic [1:0]  arm;
      op_type      op;
      int          rr;
      int          sel;
      set_config(lim, zone_code);
      t_us    = $urandom;
      step_us = 32'(lim) / 6 + 1;
      rr      = 0;
      // start every arm fresh so that checks can come back healthy
      for (int a = 0; a < ARMS; a++) begin
         send_word(OP_ARRIVAL, 2'(a), pick_zone(zone_code), t_us, FREE_NOTE);
         heard_at[a] = t_us;
      end
      for (int k = ARMS; k < words; k++) begin
         sel = $urandom_range(0, 99);
         arm = 2'($urandom);
         if (sel < 45) begin
            if (sel < 36) begin
               arm = 2'(rr);
               rr  = (rr + 1) % ARMS;
            end
            send_word(OP_ARRIVAL, arm, pick_zone(zone_code), t_us, FREE_NOTE);
            heard_at[arm] = t_us;
            t_us = t_us + $urandom_range(0, step_us);
         end else if (sel < 75) begin
            send_word(OP_CHECK, arm, 8'($urandom), t_us, FREE_NOTE);
         end else if (sel < 90) begin
            stamp = heard_at[arm] + 32'(lim) + $urandom_range(0, 2) - 32'd1;
            send_word(OP_CHECK, 2'($urandom), 8'($urandom), stamp, FREE_NOTE);
         end else begin
            op    = op_type'($urandom_range(0, 1));
            stamp = $urandom;
            send_word(op, arm, 8'($urandom), stamp, FREE_NOTE);
            if (op == OP_ARRIVAL)
               heard_at[arm] = stamp;
         end
      end
      drain();
   endtask

   // ------------------------------------------------------------------
   // Directed table, run under the reset settings (limit 3000, zone 5).
   // Verdicts are typed in where they are obvious; the rest are left to
   // the shadow. Park goes high once, on the forbidden-zone arrival, and
   // must then hold through stale and healthy checks alike.
   // ------------------------------------------------------------------
   probe_type probe_plan[DIRECTED_N] = '{
      // straight out of reset: all ages zero
      '{OP_CHECK,   2'd0, 8'h00, 32'h0000_0000, '{1'b1, '{1'b1, 1'b0}}},
      // age equal to the limit is still fine; arm and zone ignored on checks
      '{OP_CHECK,   2'd3, 8'hFF, 32'd3000,      '{1'b1, '{1'b1, 1'b0}}},
      '{OP_ARRIVAL, 2'd0, 8'h00, 32'hFFFF_FFFF, '{1'b1, '{1'b1, 1'b0}}},
      '{OP_ARRIVAL, 2'd1, 8'hFF, 32'hFFFF_F800, '{1'b1, '{1'b1, 1'b0}}},
      '{OP_ARRIVAL, 2'd2, 8'h04, 32'hFFFF_FF00, '{1'b1, '{1'b1, 1'b0}}},
      '{OP_ARRIVAL, 2'd3, 8'h06, 32'h0000_0100, '{1'b1, '{1'b1, 1'b0}}},
      // ages measured across the 32-bit wrap; forbidden zone on a check is ignored
      '{OP_CHECK,   2'd2, 8'h05, 32'h0000_0100, FREE_NOTE},
      '{OP_ARRIVAL, 2'd1, 8'hFE, 32'h0000_0200, '{1'b1, '{1'b1, 1'b0}}},
      '{OP_ARRIVAL, 2'd2, 8'hFB, 32'h0000_0300, '{1'b1, '{1'b1, 1'b0}}},
      // arm 0 exactly at the limit after the wrap
      '{OP_CHECK,   2'd1, 8'h00, 32'h0000_0BB7, FREE_NOTE},
      // forbidden zone: park latches on the arrival itself
      '{OP_ARRIVAL, 2'd3, 8'h05, 32'h0000_0BB0, '{1'b1, '{1'b1, 1'b1}}},
      // arm 0 one microsecond over
      '{OP_CHECK,   2'd1, 8'hAA, 32'h0000_0BB8, '{1'b1, '{1'b0, 1'b1}}},
      '{OP_ARRIVAL, 2'd0, 8'h00, 32'h0000_0BB8, '{1'b1, '{1'b1, 1'b1}}},
      // healthy check does not clear park
      '{OP_CHECK,   2'd0, 8'h00, 32'h0000_0BB8, FREE_NOTE},
      '{OP_CHECK,   2'd3, 8'hFF, 32'hFFFF_FFFF, FREE_NOTE},
      '{OP_CHECK,   2'd0, 8'h00, 32'h8000_0000, FREE_NOTE}
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_plan[i])
         send_word(probe_plan[i].op, probe_plan[i].arm, probe_plan[i].zone,
                   probe_plan[i].stamp, probe_plan[i].note);
      drain();

      // limit and zone extremes, a 1 s limit, the nominal 1 ms range, then something random
      run_phase(20'd0,       8'h00, 100);
      run_phase(20'hF_FFFF,  8'hFF, 100);
      run_phase(20'd1000000, 8'($urandom), 100);
      run_phase(20'd1000,    8'd5, 100);
      run_phase(20'($urandom_range(1, 6000)), 8'($urandom), 100);

      // let any stray result surface before the verdict
      repeat (8) @(posedge clock);
      if (owed_verdicts.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", owed_verdicts.size()));

      $display("covered %0d words (%0d heartbeats, %0d checks, %0d unhealthy) under %0d settings",
               words_accepted, arrivals_seen, checks_seen, unhealthy_seen, settings_run + 1);
      $display("input back-pressured for %0d cycles; %0d mismatches",
               input_stalls, mismatch_count);
      if (mismatch_count == 0)
         $display("multi_arm_heartbeat_watchdog_unit_tb passed");
      else
         $display("multi_arm_heartbeat_watchdog_unit_tb failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/mhw_pkg.sv
rtl/core/mhw_arm_table.sv
rtl/core/mhw_result_stage.sv
rtl/core/multi_arm_heartbeat_watchdog_unit.sv
tb/multi_arm_heartbeat_watchdog_unit_tb.sv
